// ===== design/bbd_pkg.sv =====
// Shared types, constants and register codes of the binary box density fill.
`timescale 1ns / 1ps

package bbd_pkg;

  // Default sizes of the column history memory and of the window.
  localparam int DEF_MAX_ROW_LENGTH  = 512;
  localparam int DEF_MAX_HALF_WINDOW = 15;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Register widths and reset values.
  localparam int LEN_W  = 10;
  localparam int ROWS_W = 10;
  localparam int HALF_W = 4;
  localparam int FRAC_W = 17;

  localparam logic [LEN_W-1:0]  RST_ROW_LENGTH    = 10'd256;
  localparam logic [ROWS_W-1:0] RST_ROW_COUNT     = 10'd256;
  localparam logic [HALF_W-1:0] RST_HALF_WINDOW   = 4'd3;
  localparam logic [FRAC_W-1:0] RST_FILL_FRACTION = 17'd36045;

  // Row position, including the tail rows past the image end.
  localparam int ROW_W = 11;
  // One column sum of at most 31 rows, a window total of at most 31 x 31.
  localparam int SUM_W = 5;
  localparam int TOT_W = 10;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH    = 2'd0,
    REG_ROW_COUNT     = 2'd1,
    REG_HALF_WINDOW   = 2'd2,
    REG_FILL_FRACTION = 2'd3
  } reg_idx_e;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ROWS_W-1:0] rows;
    logic [HALF_W-1:0] half;
    logic [FRAC_W-1:0] frac;
  } cfg_t;

  // One queued word: the column sum of the item and how the back must use it.
  typedef struct packed {
    logic [SUM_W-1:0] colsum;
    logic             row_start;
    logic             sub_in;
    logic             edge_col;
    logic             sub_edge;
    logic             emit;
    logic             fin;
    logic [TOT_W-1:0] area;
  } qent_t;

endpackage

// ===== design/bbd_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps

interface bbd_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink (input valid, input mode, input pixel_in, output ready);
endinterface

interface bbd_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic last;

  modport source (output valid, output pixel_out, output last, input ready);
  modport sink (input valid, input pixel_out, input last, output ready);
endinterface

// ===== design/bbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/bbd_front.sv =====
// Front: takes input words, tracks raster positions and builds column sums.
`timescale 1ns / 1ps

module bbd_front #(
  parameter int MaxRowLength  = bbd_pkg::DEF_MAX_ROW_LENGTH,
  parameter int MaxHalfWindow = bbd_pkg::DEF_MAX_HALF_WINDOW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bbd_pkg::cfg_t               cfg_i,
  input  logic                        restart_i,
  bbd_in_if.sink                      in_ch,
  input  logic [bbd_pkg::QCNT_W-1:0]  q_count_i,
  output logic                        q_push_o,
  output bbd_pkg::qent_t              q_data_o
);
  import bbd_pkg::*;

  localparam int CW     = (MaxRowLength > 1) ? $clog2(MaxRowLength) : 1;
  localparam int XW     = ((CW > ROW_W) ? CW : ROW_W) + 1;
  localparam int HIST_W = 2 * MaxHalfWindow + 1;
  localparam int NG     = (HIST_W + 3) / 4;
  localparam int GW     = 3;

  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d;

  logic accept;
  logic [XW-1:0] vr, vc, orow, ocol, ln, rn, hn, h2, one;
  logic wr, emit, fin;
  logic [XW-1:0] lo, hi, rlo, rhi, clo, chi;

  // First stage registers: memory read in flight.
  logic             f1_valid_q;
  qent_t            f1_ent_q;
  logic [CW-1:0]    f1_col_q;
  logic             f1_bit_q;
  logic             f1_wr_q;
  logic [SUM_W-1:0] f1_nbits_q, f1_nrows_q, f1_ncols_q;

  // Second stage registers: group counts of the masked column history.
  logic             f2_valid_q;
  qent_t            f2_ent_q;
  logic [GW-1:0]    f2_grp_q [NG];

  logic [HIST_W-1:0] hist_old, hist_new, hist_src, hist_msk;
  logic [GW-1:0]     grp_d [NG];
  logic [TOT_W-1:0]  area;
  logic [SUM_W-1:0]  colsum;
  logic              ram_we;

  assign accept = in_ch.valid && in_ch.ready;

  // Room is kept in the queue for every word still in the two stages.
  assign in_ch.ready = ({1'b0, q_count_i} + (QCNT_W + 1)'(f1_valid_q)
                       + (QCNT_W + 1)'(f2_valid_q)) < (QCNT_W + 1)'(QDEPTH);

  assign vr   = XW'(in_row_q);
  assign vc   = XW'(in_col_q);
  assign orow = XW'(out_row_q);
  assign ocol = XW'(out_col_q);
  assign ln   = XW'(cfg_i.len);
  assign rn   = XW'(cfg_i.rows);
  assign hn   = XW'(cfg_i.half);
  assign h2   = hn << 1;
  assign one  = XW'(1);

  // Classification of the current position.
  assign wr   = vr < rn;
  assign emit = (vr > hn) || ((vr == hn) && (vc >= hn));
  assign fin  = emit && (orow == rn - one) && (ocol == ln - one);

  // Rows of the column sum: from 2H rows back up to the newest image row.
  assign lo = (vr > h2) ? vr - h2 : '0;
  assign hi = wr ? vr : rn - one;

  // Clipped window extent of the result position.
  assign rlo = (orow > hn) ? orow - hn : '0;
  assign rhi = (orow + hn > rn - one) ? rn - one : orow + hn;
  assign clo = (ocol > hn) ? ocol - hn : '0;
  assign chi = (ocol + hn > ln - one) ? ln - one : ocol + hn;

  // Position counters.
  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (restart_i) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else if (accept) begin
      if (emit && fin) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
      end else begin
        if (emit) begin
          if (ocol == ln - one) begin
            out_col_d = '0;
            out_row_d = out_row_q + ROW_W'(1);
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
        end
        if (vc == ln - one) begin
          in_col_d = '0;
          in_row_d = in_row_q + ROW_W'(1);
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
      end
    end
  end

  // Column history: each column keeps its most recent rows, newest in bit 0.
  assign ram_we   = f1_valid_q && f1_wr_q;
  assign hist_new = {hist_old[HIST_W-2:0], f1_bit_q};
  assign hist_src = f1_wr_q ? hist_new : hist_old;

  bbd_ram #(
    .Width (HIST_W),
    .Depth (MaxRowLength)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (f1_col_q),
    .wdata_i (hist_new),
    .re_i    (accept),
    .raddr_i (in_col_q),
    .rdata_o (hist_old)
  );

  // Keep only the rows of the window and count them in groups of four.
  always_comb begin
    int idx;
    for (int i = 0; i < HIST_W; i++) begin
      hist_msk[i] = hist_src[i] && (i < int'(f1_nbits_q));
    end
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int b = 0; b < 4; b++) begin
        idx = 4 * g + b;
        if (idx < HIST_W) begin
          grp_d[g] = grp_d[g] + GW'(hist_msk[idx]);
        end
      end
    end
  end

  assign area = TOT_W'(f1_nrows_q) * TOT_W'(f1_ncols_q);

  // Final column sum from the group counts.
  always_comb begin
    colsum = '0;
    for (int g = 0; g < NG; g++) begin
      colsum = colsum + SUM_W'(f2_grp_q[g]);
    end
  end

  assign q_push_o = f2_valid_q;
  always_comb begin
    q_data_o        = f2_ent_q;
    q_data_o.colsum = colsum;
  end

  // Counters and stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      f1_valid_q <= accept;
      f2_valid_q <= f1_valid_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_col_q           <= in_col_q;
      f1_bit_q           <= !in_ch.mode && in_ch.pixel_in;
      f1_wr_q            <= wr;
      f1_nbits_q         <= SUM_W'(hi - lo + one);
      f1_nrows_q         <= SUM_W'(rhi - rlo + one);
      f1_ncols_q         <= SUM_W'(chi - clo + one);
      f1_ent_q.colsum    <= '0;
      f1_ent_q.row_start <= (vc == '0);
      f1_ent_q.sub_in    <= (vc >= h2 + one);
      f1_ent_q.edge_col  <= (vc < hn);
      f1_ent_q.sub_edge  <= (vc + ln >= h2 + one);
      f1_ent_q.emit      <= emit;
      f1_ent_q.fin       <= fin;
      f1_ent_q.area      <= '0;
    end
    if (f1_valid_q) begin
      f2_ent_q      <= f1_ent_q;
      f2_ent_q.area <= area;
      f2_grp_q      <= grp_d;
    end
  end

  // The history read and the write of the previous word never share a column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && accept) |-> (f1_col_q != in_col_q))
    else $error("history read and write hit the same column");

  // The last result of an image sends every position back to the start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit && fin) |=> ((in_row_q == '0) && (in_col_q == '0)
                                  && (out_row_q == '0) && (out_col_q == '0)))
    else $error("positions not cleared after the last result");

  // The input column stays inside the row while words arrive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (vc < ln))
    else $error("input column outside the row");

endmodule

// ===== design/bbd_fifo.sv =====
// Short queue of column-sum words between the front and the back.
`timescale 1ns / 1ps

module bbd_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  bbd_pkg::qent_t             data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output bbd_pkg::qent_t             data_o,
  output logic [bbd_pkg::QCNT_W-1:0] count_o
);
  import bbd_pkg::*;

  qent_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // The front must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCNT_W'(QDEPTH)))
    else $error("push into a full queue");

endmodule

// ===== design/bbd_back.sv =====
// Back: running window totals, density compare and the result register.
`timescale 1ns / 1ps

module bbd_back #(
  parameter int MaxHalfWindow = bbd_pkg::DEF_MAX_HALF_WINDOW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bbd_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  bbd_pkg::qent_t q_data_i,
  output logic           q_pop_o,
  bbd_out_if.source      out_ch
);
  import bbd_pkg::*;

  localparam int TAPN = 2 * MaxHalfWindow + 1;
  localparam int TAPW = (TAPN > 1) ? $clog2(TAPN) : 1;
  localparam int PW   = FRAC_W + TOT_W;

  logic [SUM_W-1:0] sr_q [TAPN];
  logic [TOT_W-1:0] tot_q, tot_d, ext_q, ext_d, ones_d;
  logic [TOT_W-1:0] cs, tap, tap_in, tap_edge;
  logic [TAPW-1:0]  tap_idx;

  logic             en1, en2, en3;
  logic             b1v_q, pv_q, ov_q;
  logic [TOT_W-1:0] b1_ones_q, b1_area_q;
  logic             b1_fin_q;
  logic [PW-1:0]    prod_q;
  logic [TOT_W-1:0] p_ones_q;
  logic             p_fin_q;
  logic             pix_q, last_q;

  // Stage enables, from the result register backward.
  assign en3     = !ov_q || out_ch.ready;
  assign en2     = !pv_q || en3;
  assign en1     = !b1v_q || en2;
  assign q_pop_o = en1 && q_valid_i;

  // Column sum of the word that left the window, 2H+1 words back.
  assign tap_idx  = TAPW'({cfg_i.half, 1'b0});
  assign cs       = TOT_W'(q_data_i.colsum);
  assign tap      = TOT_W'(sr_q[tap_idx]);
  assign tap_in   = q_data_i.sub_in ? tap : '0;
  assign tap_edge = q_data_i.sub_edge ? tap : '0;

  // Row total grows along the row; the edge total serves the right edge
  // results that fall in the first columns of the next row.
  always_comb begin
    tot_d = tot_q;
    ext_d = ext_q;
    if (q_data_i.row_start) begin
      tot_d = cs;
      ext_d = tot_q - tap_edge;
    end else begin
      tot_d = tot_q + cs - tap_in;
      if (q_data_i.edge_col) begin
        ext_d = ext_q - tap_edge;
      end
    end
    ones_d = q_data_i.edge_col ? ext_d : tot_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      ext_q <= '0;
      b1v_q <= 1'b0;
      pv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (q_pop_o) begin
        tot_q <= tot_d;
        ext_q <= ext_d;
      end
      if (en1) begin
        b1v_q <= q_pop_o && q_data_i.emit;
      end
      if (en2) begin
        pv_q <= b1v_q;
      end
      if (en3) begin
        ov_q <= pv_q;
      end
    end
  end

  // Payload registers: tap line, totals, product and result word.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      sr_q[0] <= q_data_i.colsum;
      for (int i = 1; i < TAPN; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
    if (en1) begin
      b1_ones_q <= ones_d;
      b1_area_q <= q_data_i.area;
      b1_fin_q  <= q_data_i.fin;
    end
    if (en2) begin
      prod_q   <= PW'(cfg_i.frac) * PW'(b1_area_q);
      p_ones_q <= b1_ones_q;
      p_fin_q  <= b1_fin_q;
    end
    if (en3) begin
      pix_q  <= ({p_ones_q, 16'd0} > prod_q);
      last_q <= p_fin_q;
    end
  end

  assign out_ch.valid     = ov_q;
  assign out_ch.pixel_out = pix_q;
  assign out_ch.last      = last_q;

endmodule

// ===== design/binary_box_density_fill.sv =====
// Top level of the binary box density fill: registers, front, queue, back.
//
//   channel   dir  handshake    word
//   in_ch     in   valid/ready  mode, pixel_in
//   out_ch    out  valid/ready  pixel_out, last
//   cfg       in   cfg_we_i     cfg_idx_i, cfg_data_i
//
// One input word per cycle while the queue has room; each word takes one
// column-history read and one write in the same memory, the write in the
// cycle after the read, which sets that rate.
// No clearing pass after reset: a window reads only rows of its own image.
// Either side may stall; the queue and the result register absorb it.
`timescale 1ns / 1ps

module binary_box_density_fill #(
  parameter int MaxRowLength  = bbd_pkg::DEF_MAX_ROW_LENGTH,
  parameter int MaxHalfWindow = bbd_pkg::DEF_MAX_HALF_WINDOW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bbd_in_if.sink                          in_ch,
  bbd_out_if.source                       out_ch,
  input  logic                            cfg_we_i,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bbd_pkg::*;

  logic [LEN_W-1:0]  len_q;
  logic [ROWS_W-1:0] rows_q;
  logic [HALF_W-1:0] half_q;
  logic [FRAC_W-1:0] frac_q;
  logic              restart;
  cfg_t              cfg;

  logic              q_push, q_pop, q_valid;
  qent_t             q_wdata, q_rdata;
  logic [QCNT_W-1:0] q_count;

  // Register writes; any write to a listed register restarts the image.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= RST_ROW_LENGTH;
      rows_q <= RST_ROW_COUNT;
      half_q <= RST_HALF_WINDOW;
      frac_q <= RST_FILL_FRACTION;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROW_LENGTH:    len_q  <= cfg_data_i[LEN_W-1:0];
        REG_ROW_COUNT:     rows_q <= cfg_data_i[ROWS_W-1:0];
        REG_HALF_WINDOW:   half_q <= cfg_data_i[HALF_W-1:0];
        REG_FILL_FRACTION: frac_q <= cfg_data_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROW_LENGTH, REG_ROW_COUNT, REG_HALF_WINDOW, REG_FILL_FRACTION: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  // Clamp the registers to the supported ranges.
  always_comb begin
    logic [LEN_W-1:0] l;
    logic [ROWS_W-1:0] r;
    logic [LEN_W-1:0] h;
    l = len_q;
    if (l < LEN_W'(2)) begin
      l = LEN_W'(2);
    end
    if (int'(l) > MaxRowLength) begin
      l = LEN_W'(MaxRowLength);
    end
    r = rows_q;
    if (r < ROWS_W'(2)) begin
      r = ROWS_W'(2);
    end
    h = LEN_W'(half_q);
    if (h == '0) begin
      h = LEN_W'(1);
    end
    if (int'(h) > MaxHalfWindow) begin
      h = LEN_W'(MaxHalfWindow);
    end
    if (h > (l >> 1)) begin
      h = l >> 1;
    end
    if (h > LEN_W'(r >> 1)) begin
      h = LEN_W'(r >> 1);
    end
    cfg.len  = l;
    cfg.rows = r;
    cfg.half = HALF_W'(h);
    cfg.frac = frac_q;
  end

  bbd_front #(
    .MaxRowLength  (MaxRowLength),
    .MaxHalfWindow (MaxHalfWindow)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .in_ch     (in_ch),
    .q_count_i (q_count),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  bbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .count_o (q_count)
  );

  bbd_back #(
    .MaxHalfWindow (MaxHalfWindow)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== test/binary_box_density_fill_tb.sv =====
// Self-checking testbench of the binary box density fill, with a predicting scoreboard.
`timescale 1ns / 1ps

module binary_box_density_fill_tb;
  import bbd_pkg::*;

  // Scoreboard: predicts the filtered mask and checks each result word.
  class density_scoreboard;
    bit [9:0]  row_length;
    bit [9:0]  row_count;
    bit [3:0]  half_window;
    bit [16:0] fill_fraction;
    bit [63:0] column_bits [512];
    int unsigned in_row, in_col, out_row, out_col;
    bit [1:0]  expected_words [$];
    int        mismatches;

    function new();
      row_length    = RST_ROW_LENGTH;
      row_count     = RST_ROW_COUNT;
      half_window   = RST_HALF_WINDOW;
      fill_fraction = RST_FILL_FRACTION;
      foreach (column_bits[i]) column_bits[i] = '0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function int unsigned eff_len();
      int unsigned l;
      l = row_length;
      if (l < 2) l = 2;
      if (l > 512) l = 512;
      return l;
    endfunction

    function int unsigned eff_rows();
      return (row_count < 2) ? 2 : row_count;
    endfunction

    function int unsigned eff_half();
      int unsigned h;
      h = half_window;
      if (h < 1) h = 1;
      if (h > 15) h = 15;
      if (h > eff_len() / 2) h = eff_len() / 2;
      if (h > eff_rows() / 2) h = eff_rows() / 2;
      return h;
    endfunction

    // Number of words one whole image takes, tail included.
    function int unsigned image_words();
      return eff_rows() * eff_len() + eff_half() * eff_len() + eff_half();
    endfunction

    function void write_reg(reg_idx_e idx, bit [16:0] value);
      case (idx)
        REG_ROW_LENGTH:    row_length = value[9:0];
        REG_ROW_COUNT:     row_count = value[9:0];
        REG_HALF_WINDOW:   half_window = value[3:0];
        REG_FILL_FRACTION: fill_fraction = value;
        default: ;
      endcase
      restart();
    endfunction

    // Window density decision for one raster position.
    function bit density(int orow, int ocol, int vr, int vc, int l, int r, int h);
      int r0, r1, c0, c1, lastr, k;
      longint unsigned ones, n;
      ones = 0;
      n = 0;
      r0 = (orow - h < 0) ? 0 : orow - h;
      c0 = (ocol - h < 0) ? 0 : ocol - h;
      r1 = (orow + h > r - 1) ? r - 1 : orow + h;
      c1 = (ocol + h > l - 1) ? l - 1 : ocol + h;
      for (int c = c0; c <= c1; c++) begin
        lastr = (c <= vc) ? vr : vr - 1;
        if (lastr > r - 1) lastr = r - 1;
        for (int rr = r0; rr <= r1; rr++) begin
          k = lastr - rr;
          n++;
          if (k >= 0 && k < 64) ones += column_bits[c][k];
        end
      end
      return (ones * 65536 > longint'(fill_fraction) * n);
    endfunction

    function void note_input(bit mode, bit pixel);
      int unsigned l, r, h, vr, vc;
      bit fin;
      l = eff_len();
      r = eff_rows();
      h = eff_half();
      if (in_col >= l || in_row > r + h || out_col >= l || out_row >= r) restart();
      vr = in_row;
      vc = in_col;
      // A flush inside the image counts as a zero pixel.
      if (vr < r) column_bits[vc] = {column_bits[vc][62:0], (mode == 1'b0) ? pixel : 1'b0};
      if (vr > h || (vr == h && vc >= h)) begin
        fin = (out_row == r - 1 && out_col == l - 1);
        expected_words.push_back({density(out_row, out_col, vr, vc, l, r, h), fin});
        if (fin) begin
          restart();
          return;
        end
        out_col++;
        if (out_col == l) begin
          out_col = 0;
          out_row++;
        end
      end
      in_col++;
      if (in_col == l) begin
        in_col = 0;
        in_row++;
      end
    endfunction

    function void check_result(bit pixel_out, bit last);
      bit [1:0] want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: pixel %0b last %0b",
                                       pixel_out, last);
        return;
      end
      want = expected_words.pop_front();
      if (want != {pixel_out, last}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected pixel %0b last %0b, got pixel %0b last %0b",
                   want[1], want[0], pixel_out, last);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bbd_in_if  in_ch ();
  bbd_out_if out_ch ();

  density_scoreboard sb;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int words_sent;
  bit held;

  binary_box_density_fill DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.pixel_out, out_ch.last);
  end

  // Wait until every expected word has arrived, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic setup(int len, int rows, int half, int frac);
    write_reg(REG_ROW_LENGTH, len);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_HALF_WINDOW, half);
    write_reg(REG_FILL_FRACTION, frac);
  endtask

  // Offer one word and hold it until accepted; random idle cycles before it.
  task automatic send_word(bit mode, bit pixel);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.pixel_in <= pixel;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(mode, pixel);
    words_sent++;
  endtask

  // One whole image: pixels of the given density, then flush words for the tail.
  // With noise, some pixels become flushes and some tail flushes carry pixels.
  task automatic send_image(int ones_pct, bit noise);
    int unsigned body, total;
    body = sb.eff_rows() * sb.eff_len();
    total = sb.image_words();
    for (int unsigned p = 0; p < total; p++) begin
      if (p < body) begin
        if (noise && $urandom_range(9) == 0) send_word(1'b1, $urandom_range(1));
        else send_word(1'b0, $urandom_range(99) < ones_pct);
      end else begin
        if (noise && $urandom_range(3) == 0) send_word(1'b0, $urandom_range(1));
        else send_word(1'b1, $urandom_range(1));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.pixel_in = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    words_sent = 0;
    held = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a few words at reset settings, then size and threshold extremes.
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b0);
    setup(2, 2, 1, 0);
    send_image(100, 1'b0);
    setup(3, 2, 0, 65536);
    send_image(100, 1'b0);
    setup(1, 0, 15, 131071);
    send_image(100, 1'b1);
    setup(1023, 2, 1, 32768);
    for (int i = 0; i < 520; i++) send_word(1'b0, $urandom_range(1));
    setup(2, 1023, 1, 65535);
    for (int i = 0; i < 20; i++) send_word(1'b0, 1'b1);
    setup(8, 8, 15, 36045);
    send_image(60, 1'b1);
    setup(512, 512, 15, 20000);
    for (int i = 0; i < 20; i++) send_word(1'b0, $urandom_range(1));

    // Random images over phases of input idling and receiver stalls.
    words_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 36 : 0;
      stall_pct = (ph == 2) ? 70 : (ph == 3) ? 36 : 0;
      while (words_sent < (ph + 1) * 100) begin
        if ($urandom_range(1)) write_reg(REG_ROW_LENGTH, $urandom_range(12, 2) | ($urandom_range(1) << 16));
        if ($urandom_range(1)) write_reg(REG_ROW_COUNT, $urandom_range(10, 2));
        if ($urandom_range(1)) write_reg(REG_HALF_WINDOW, $urandom_range(15));
        if ($urandom_range(1)) write_reg(REG_FILL_FRACTION,
                                         ($urandom_range(15) == 0) ? 17'h1FFFF : $urandom_range(65536));
        if (ph == 0 && !held) begin
          // An image of the largest random size against a long receiver hold fills the block.
          held = 1'b1;
          setup(12, 10, 3, 36045);
          hold_req <= 1'b1;
          send_image(50, 1'b0);
          drain();
        end else begin
          send_image($urandom_range(100), $urandom_range(3) == 0);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
